/* design/hessian_ridge_polarity_marker_assert.svh */
// assertion macros for the hessian ridge polarity marker rtl
`ifndef HESSIAN_RIDGE_POLARITY_MARKER_ASSERT_SVH
`define HESSIAN_RIDGE_POLARITY_MARKER_ASSERT_SVH

// same-cycle implication
`define HRPM_ASSERT_IMPLY(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define HRPM_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

/* design/hrpm_pkg.sv */
// shared types and constants of the hessian ridge polarity marker
`default_nettype none
package hrpm_pkg;

    localparam int PIX_W               = 16;
    localparam int INDEX_W             = 20;
    localparam int RESP_W              = 41;
    localparam int PIXEL_FRACTION_BITS = 8;
    localparam int SCALE_SHIFT         = 6;
    localparam int RATIO_FRACTION_BITS = 8;
    localparam int LIM_W               = 16 + PIXEL_FRACTION_BITS + 1;
    localparam int ROOT_STEPS          = 32;
    localparam int QUEUE_DEPTH         = 4;
    localparam int PIXEL_COUNT_DEF     = 1048576;
    localparam longint RESP_MAX        = (64'sd1 <<< (RESP_W - 1)) - 64'sd1;

    localparam logic [1:0] REG_SIGMA_SQUARED  = 2'd0;
    localparam logic [1:0] REG_RATIO_LIMIT    = 2'd1;
    localparam logic [1:0] REG_STRENGTH_LIMIT = 2'd2;

    typedef struct packed {
        logic [15:0] sigma_squared;
        logic [8:0]  ratio_limit;
        logic [15:0] strength_limit;
    } cfg_t;

    typedef struct packed {
        logic [INDEX_W-1:0] idx;
        logic               fresh;
    } tag_t;

    typedef struct packed {
        tag_t               tag;
        logic signed [32:0] p;
    } root_side_t;

    typedef struct packed {
        tag_t                     tag;
        logic signed [RESP_W-1:0] resp;
    } item_t;

    typedef struct packed {
        logic neg;
        logic pos;
    } marks_t;

    typedef struct packed {
        logic                     light;
        logic                     dark;
        logic signed [RESP_W-1:0] resp;
        logic [INDEX_W-1:0]       idx;
    } result_t;

endpackage
`default_nettype wire

/* design/hrpm_ram.sv */
// generic single write port ram with registered read
`default_nettype none
module hrpm_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

/* design/hrpm_sqrt.sv */
// pipelined integer square root, one result bit per stage
`default_nettype none
module hrpm_sqrt import hrpm_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [63:0] in_disc,
    input  wire root_side_t  in_side,
    output logic             out_valid,
    output logic [31:0]      out_root,
    output root_side_t       out_side
);

    logic       valid_reg [1:ROOT_STEPS];
    logic [63:0] v_reg    [1:ROOT_STEPS];
    logic [63:0] r_reg    [1:ROOT_STEPS];
    root_side_t side_reg  [1:ROOT_STEPS];

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] v_in, r_in, v_out, r_out, trial;
        root_side_t  side_in;
        logic        valid_in;

        if (k == 0) begin : g_first
            assign v_in     = in_disc;
            assign r_in     = '0;
            assign side_in  = in_side;
            assign valid_in = in_valid;
        end else begin : g_next
            assign v_in     = v_reg[k];
            assign r_in     = r_reg[k];
            assign side_in  = side_reg[k];
            assign valid_in = valid_reg[k];
        end

        assign trial = r_in + BIT;

        always_comb begin
            if (v_in >= trial) begin
                v_out = v_in - trial;
                r_out = (r_in >> 1) + BIT;
            end else begin
                v_out = v_in;
                r_out = r_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                valid_reg[k+1] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[k+1]    <= v_out;
                r_reg[k+1]    <= r_out;
                side_reg[k+1] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_STEPS];
    assign out_root  = r_reg[ROOT_STEPS][31:0];
    assign out_side  = side_reg[ROOT_STEPS];

endmodule
`default_nettype wire

/* design/hrpm_front.sv */
// front pipeline: hessian, eigenvalues, ratio and strength tests
`default_nettype none
module hrpm_front import hrpm_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [8:0][PIX_W-1:0] in_pix,
    input  wire tag_t                  in_tag,
    input  wire cfg_t                  cfg,
    output logic                       out_valid,
    output item_t                      out_item
);

    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned n);
        logic [63:0] mag;
        logic [63:0] m;
        mag = v[63] ? 64'(-v) : 64'(v);
        m   = (mag + (64'd1 << (n - 1))) >> n;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    logic [5:0] head_valid_reg;
    logic [2:0] tail_valid_reg;

    // stage 1
    logic signed [21:0] e [9];
    logic signed [21:0] sxx_c, syy_c;
    logic signed [18:0] sxy_c;
    logic signed [21:0] sxx1_reg, syy1_reg;
    logic signed [18:0] sxy1_reg;
    tag_t tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg, tag6_reg;
    // stage 2
    logic signed [38:0] pxx2_reg, pyy2_reg;
    logic signed [35:0] pxy2_reg;
    // stage 3
    logic signed [31:0] a3_reg, c3_reg, b3_reg;
    // stage 4
    logic signed [32:0] p4_reg, q4_reg;
    logic [31:0] bm4_reg;
    logic [31:0] qm;
    // stage 5
    logic [63:0] qq5_reg, bb5_reg;
    logic signed [32:0] p5_reg;
    // stage 6
    logic [63:0] disc6_reg;
    logic signed [32:0] p6_reg;
    // root
    logic        root_valid;
    logic [31:0] root;
    root_side_t  root_side;
    // stage 7
    logic signed [33:0] pe, se, big_c, sm_c, big_o, sm_o;
    logic [33:0] mbig, msm;
    logic signed [33:0] big7_reg;
    logic [31:0] mb7_reg, ms7_reg;
    tag_t tag7_reg, tag8_reg, tag9_reg;
    // stage 8
    logic [LIM_W-1:0] lim;
    logic [40:0] rprod8_reg;
    logic [31+RATIO_FRACTION_BITS:0] mssh8_reg;
    logic [63:0] mb2_8_reg, ms2_8_reg;
    logic [2*LIM_W-1:0] lim2_8_reg;
    logic signed [33:0] big8_reg;
    // stage 9
    logic drop;
    logic signed [63:0] half;
    logic signed [RESP_W-1:0] resp_c, resp9_reg;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            e[k] = $signed({6'b0, in_pix[k]});
        end
    end

    assign sxx_c = e[0] - (e[1] <<< 1) + e[2] + ((e[3] - (e[4] <<< 1) + e[5]) <<< 1)
                 + e[6] - (e[7] <<< 1) + e[8];
    assign syy_c = e[0] + (e[1] <<< 1) + e[2] - ((e[3] + (e[4] <<< 1) + e[5]) <<< 1)
                 + e[6] + (e[7] <<< 1) + e[8];
    assign sxy_c = 19'(e[0] - e[2] - e[6] + e[8]);

    assign qm = q4_reg[32] ? 32'(-q4_reg) : 32'(q4_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= '0;
            tail_valid_reg <= '0;
        end else if (en) begin
            head_valid_reg <= {head_valid_reg[4:0], in_valid};
            tail_valid_reg <= {tail_valid_reg[1:0], root_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sxx1_reg  <= sxx_c;
            syy1_reg  <= syy_c;
            sxy1_reg  <= sxy_c;
            tag1_reg  <= in_tag;

            pxx2_reg  <= 39'(sxx1_reg) * 39'($signed({1'b0, cfg.sigma_squared}));
            pyy2_reg  <= 39'(syy1_reg) * 39'($signed({1'b0, cfg.sigma_squared}));
            pxy2_reg  <= 36'(sxy1_reg) * 36'($signed({1'b0, cfg.sigma_squared}));
            tag2_reg  <= tag1_reg;

            a3_reg    <= 32'(rnd_shift(64'(pxx2_reg), SCALE_SHIFT));
            c3_reg    <= 32'(rnd_shift(64'(pyy2_reg), SCALE_SHIFT));
            b3_reg    <= 32'(rnd_shift(64'(pxy2_reg), SCALE_SHIFT));
            tag3_reg  <= tag2_reg;

            p4_reg    <= 33'(a3_reg) + 33'(c3_reg);
            q4_reg    <= 33'(a3_reg) - 33'(c3_reg);
            bm4_reg   <= b3_reg[31] ? 32'(-b3_reg) : 32'(b3_reg);
            tag4_reg  <= tag3_reg;

            qq5_reg   <= 64'(qm) * 64'(qm);
            bb5_reg   <= 64'(bm4_reg) * 64'(bm4_reg);
            p5_reg    <= p4_reg;
            tag5_reg  <= tag4_reg;

            disc6_reg <= qq5_reg + (bb5_reg << 2);
            p6_reg    <= p5_reg;
            tag6_reg  <= tag5_reg;
        end
    end

    hrpm_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (head_valid_reg[5]),
        .in_disc   (disc6_reg),
        .in_side   ('{tag: tag6_reg, p: p6_reg}),
        .out_valid (root_valid),
        .out_root  (root),
        .out_side  (root_side)
    );

    always_comb begin
        pe    = 34'(root_side.p);
        se    = $signed({2'b0, root});
        big_c = pe + se;
        sm_c  = pe - se;
        mbig  = big_c[33] ? 34'(-big_c) : 34'(big_c);
        msm   = sm_c[33] ? 34'(-sm_c) : 34'(sm_c);
        if (mbig < msm) begin
            big_o = sm_c;
            sm_o  = big_c;
        end else begin
            big_o = big_c;
            sm_o  = sm_c;
        end
    end

    assign lim = LIM_W'(cfg.strength_limit) << (PIXEL_FRACTION_BITS + 1);

    always_comb begin
        drop = (41'(mssh8_reg) > rprod8_reg)
            || (65'(mb2_8_reg) + 65'(ms2_8_reg) < 65'(lim2_8_reg));
        half = rnd_shift(64'(big8_reg), 1);
        if (drop) begin
            resp_c = '0;
        end else if (half > RESP_MAX) begin
            resp_c = RESP_W'(RESP_MAX);
        end else if (half < -RESP_MAX) begin
            resp_c = RESP_W'(-RESP_MAX);
        end else begin
            resp_c = RESP_W'(half);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            big7_reg   <= big_o;
            mb7_reg    <= big_o[33] ? 32'(-big_o) : 32'(big_o);
            ms7_reg    <= sm_o[33] ? 32'(-sm_o) : 32'(sm_o);
            tag7_reg   <= root_side.tag;

            rprod8_reg <= 41'(cfg.ratio_limit) * 41'(mb7_reg);
            mssh8_reg  <= {ms7_reg, {RATIO_FRACTION_BITS{1'b0}}};
            mb2_8_reg  <= 64'(mb7_reg) * 64'(mb7_reg);
            ms2_8_reg  <= 64'(ms7_reg) * 64'(ms7_reg);
            lim2_8_reg <= (2*LIM_W)'(lim) * (2*LIM_W)'(lim);
            big8_reg   <= big7_reg;
            tag8_reg   <= tag7_reg;

            resp9_reg  <= resp_c;
            tag9_reg   <= tag8_reg;
        end
    end

    assign out_valid = tail_valid_reg[2];
    assign out_item  = '{tag: tag9_reg, resp: resp9_reg};

endmodule
`default_nettype wire

/* design/hrpm_fifo.sv */
// short queue between front pipeline and flag back end
`default_nettype none
module hrpm_fifo import hrpm_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire item_t din,
    input  wire logic  pop,
    output item_t      dout,
    output logic       full,
    output logic       empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t         mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push_ok, pop_ok;

    assign full    = count_reg == CW'(DEPTH);
    assign empty   = count_reg == '0;
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            count_next = count_reg + 1'b1;
        end else if (pop_ok && !push_ok) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule
`default_nettype wire

/* design/hrpm_back.sv */
// back end: per-pixel polarity flag read-modify-write and result register
`default_nettype none
`include "hessian_ridge_polarity_marker_assert.svh"
module hrpm_back import hrpm_pkg::*; #(
    parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  q_valid,
    input  wire item_t q_item,
    output logic       q_pop,
    output logic       clr_busy,
    output logic       m_valid,
    input  wire logic  m_ready,
    output result_t    m_result
);

    localparam int DEPTH = (PIXEL_COUNT > (1 << INDEX_W)) ? (1 << INDEX_W) : PIXEL_COUNT;
    localparam int AW    = $clog2(DEPTH);

    logic          a_valid_reg, b_valid_reg;
    item_t         a_item_reg, b_item_reg;
    logic          byp_valid_reg;
    logic [AW-1:0] byp_addr_reg;
    marks_t        byp_marks_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    logic          a_ready, b_ready, b_fire, b_inside, clr_last;
    logic [AW-1:0] a_addr, b_addr, raddr, waddr;
    marks_t        ram_q, old_marks, new_marks, wdata;
    logic          we, resp_neg, resp_pos;

    assign a_addr   = a_item_reg.tag.idx[AW-1:0];
    assign b_addr   = b_item_reg.tag.idx[AW-1:0];
    assign b_ready  = !b_valid_reg || m_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign b_fire   = b_valid_reg && m_ready;
    assign q_pop    = q_valid && a_ready && !clr_busy_reg;
    assign b_inside = {{(32-INDEX_W){1'b0}}, b_item_reg.tag.idx} < 32'(PIXEL_COUNT);
    assign clr_last = clr_addr_reg == AW'(DEPTH - 1);
    assign clr_busy = clr_busy_reg;

    always_comb begin
        if (!b_inside || b_item_reg.tag.fresh) begin
            old_marks = '0;
        end else if (byp_valid_reg && byp_addr_reg == b_addr) begin
            old_marks = byp_marks_reg;
        end else begin
            old_marks = ram_q;
        end
        resp_neg      = b_item_reg.resp[RESP_W-1];
        resp_pos      = !b_item_reg.resp[RESP_W-1] && (b_item_reg.resp != '0);
        new_marks.neg = old_marks.neg || (resp_neg && !old_marks.pos);
        new_marks.pos = old_marks.pos || (resp_pos && !new_marks.neg);
    end

    assign raddr = b_ready ? a_addr : b_addr;
    assign we    = clr_busy_reg || (b_fire && b_inside);
    assign waddr = clr_busy_reg ? clr_addr_reg : b_addr;
    assign wdata = clr_busy_reg ? marks_t'('0) : new_marks;

    hrpm_ram #(
        .WIDTH ($bits(marks_t)),
        .DEPTH (DEPTH)
    ) u_marks (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            byp_valid_reg <= 1'b0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= q_pop;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            byp_valid_reg <= b_fire && b_inside;
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_last) begin
                    clr_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            a_item_reg <= q_item;
        end
        if (b_ready && a_valid_reg) begin
            b_item_reg <= a_item_reg;
        end
        if (b_fire) begin
            byp_addr_reg  <= b_addr;
            byp_marks_reg <= new_marks;
        end
    end

    assign m_valid  = b_valid_reg;
    assign m_result = '{light: new_marks.pos, dark: new_marks.neg,
                        resp: b_item_reg.resp, idx: b_item_reg.tag.idx};

    `HRPM_ASSERT_IMPLY(a_clear_idle, aclk, aresetn, clr_busy_reg, !a_valid_reg && !b_valid_reg, "item in back end during clearing pass")
    `HRPM_ASSERT_IMPLY(a_marks_exclusive, aclk, aresetn, b_valid_reg, !(new_marks.neg && new_marks.pos), "both polarity flags set")
    `HRPM_ASSERT_NEXT(a_clear_ends, aclk, aresetn, clr_busy_reg && clr_last, !clr_busy_reg, "clearing pass did not end")

endmodule
`default_nettype wire

/* design/hessian_ridge_polarity_marker.sv */
// top level of the hessian ridge polarity marker
//
//  channel  | direction | transaction
//  s_axis   | in        | 3x3 uq8.8 neighborhood, pixel index, new image flag
//  m_axis   | out       | pixel index, response, dark and light flags
//  apb      | in        | sigma_squared, ratio_limit, strength_limit
//
//  one item accepted per cycle while s_tready is high; s_tready is low while the front pipeline holds
//  the front pipeline holds the 32-stage square root pipeline plus 9 arithmetic stages
//  after reset the flag store's min(PIXEL_COUNT, 2^20) entries are cleared, s_tready low
//  a stalled m side fills the 4-entry queue, then the front pipeline holds
`default_nettype none
module hessian_ridge_polarity_marker import hrpm_pkg::*; #(
    parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // up_left, up_mid, up_right, mid_left, center, mid_right,
    // low_left, low_mid, low_right, pixel_index, zero fill
    input  wire logic [167:0] s_tdata,
    // new_image
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_index, response, dark_on_light, light_on_dark, zero fill
    output logic [63:0]       m_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t    cfg_reg;
    logic    cfg_we;
    logic    front_en, front_valid, fifo_full, fifo_empty, fifo_pop, clr_busy;
    item_t   front_item, fifo_item;
    result_t result;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sigma_squared  <= 16'd12;
            cfg_reg.ratio_limit    <= 9'd230;
            cfg_reg.strength_limit <= 16'd23;
        end else if (cfg_we) begin
            case (paddr[3:2])
                REG_SIGMA_SQUARED:  cfg_reg.sigma_squared  <= pwdata[15:0];
                REG_RATIO_LIMIT:    cfg_reg.ratio_limit    <= pwdata[8:0];
                REG_STRENGTH_LIMIT: cfg_reg.strength_limit <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SIGMA_SQUARED:  prdata = {16'b0, cfg_reg.sigma_squared};
            REG_RATIO_LIMIT:    prdata = {23'b0, cfg_reg.ratio_limit};
            REG_STRENGTH_LIMIT: prdata = {16'b0, cfg_reg.strength_limit};
            default:            prdata = '0;
        endcase
    end

    assign front_en = !(front_valid && fifo_full);
    assign s_tready = front_en && !clr_busy;

    hrpm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (front_en),
        .in_valid  (s_tvalid && s_tready),
        .in_pix    (s_tdata[143:0]),
        .in_tag    ('{idx: s_tdata[163:144], fresh: s_tuser[0]}),
        .cfg       (cfg_reg),
        .out_valid (front_valid),
        .out_item  (front_item)
    );

    hrpm_fifo u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (front_valid),
        .din     (front_item),
        .pop     (fifo_pop),
        .dout    (fifo_item),
        .full    (fifo_full),
        .empty   (fifo_empty)
    );

    hrpm_back #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (!fifo_empty),
        .q_item   (fifo_item),
        .q_pop    (fifo_pop),
        .clr_busy (clr_busy),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    assign m_tdata = {1'b0, result};

endmodule
`default_nettype wire

/* tb/hessian_ridge_polarity_marker_tb.sv */
// testbench of the hessian ridge polarity marker: directed and random pixels checked against a predictor
`default_nettype none
module hessian_ridge_polarity_marker_tb;
    import hrpm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4_000_000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int REPORT_LIMIT   = 30;
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [167:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    hessian_ridge_polarity_marker dut (.*);

    always #5 aclk = ~aclk;

    // predictor state
    logic [15:0] sigma_sq_q;
    logic [8:0]  ratio_q;
    logic [15:0] strength_q;
    bit          dark_marks[int];
    bit          light_marks[int];
    result_t     expected_results[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_cycles = 0;
    int fail_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int nonzero_count = 0;
    int idle_cycles = 0;
    bit apb_active = 1'b0;

    function automatic longint round_half_away(longint v, int n);
        longint unsigned m;
        m = v < 0 ? -v : v;
        m = (m + (64'd1 << (n - 1))) >> n;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned sqrt_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic result_t predict_ridge(logic [15:0] px[9], logic [19:0] idx, bit fresh);
        longint sxx, syy, sxy, a, c, b, p, q, big, little, t, resp;
        longint unsigned disc, mb, ms, lim;
        bit drop, dark_old, light_old, dark_new, light_new;
        result_t r;
        sxx = (px[0] - 2 * px[1] + px[2]) + 2 * (px[3] - 2 * px[4] + px[5])
            + (px[6] - 2 * px[7] + px[8]);
        syy = (px[0] + 2 * px[1] + px[2]) - 2 * (px[3] + 2 * px[4] + px[5])
            + (px[6] + 2 * px[7] + px[8]);
        sxy = px[0] - px[2] - px[6] + px[8];
        a = round_half_away(sxx * sigma_sq_q, SCALE_SHIFT);
        c = round_half_away(syy * sigma_sq_q, SCALE_SHIFT);
        b = round_half_away(sxy * sigma_sq_q, SCALE_SHIFT);
        p = a + c;
        q = a - c;
        disc = longint'(q * q) + 4 * longint'(b * b);
        big = p + longint'(sqrt_floor(disc));
        little = p - longint'(sqrt_floor(disc));
        mb = big < 0 ? -big : big;
        ms = little < 0 ? -little : little;
        if (mb < ms) begin
            t = big; big = little; little = t;
            mb = big < 0 ? -big : big;
            ms = little < 0 ? -little : little;
        end
        lim = longint'(strength_q) << (PIXEL_FRACTION_BITS + 1);
        drop = ((ms << RATIO_FRACTION_BITS) > ratio_q * mb) || (mb * mb + ms * ms < lim * lim);
        resp = drop ? 0 : round_half_away(big, 1);
        if (resp > RESP_MAX) resp = RESP_MAX;
        if (resp < -RESP_MAX) resp = -RESP_MAX;
        dark_old = 0;
        light_old = 0;
        if (!fresh) begin
            if (dark_marks.exists(idx)) dark_old = dark_marks[idx];
            if (light_marks.exists(idx)) light_old = light_marks[idx];
        end
        dark_new = dark_old || (resp < 0 && !light_old);
        light_new = light_old || (resp > 0 && !dark_new);
        dark_marks[idx] = dark_new;
        light_marks[idx] = light_new;
        r.idx = idx;
        r.resp = resp[RESP_W-1:0];
        r.dark = dark_new;
        r.light = light_new;
        return r;
    endfunction

    task automatic send_pixel(logic [15:0] px[9], logic [19:0] idx, bit fresh);
        int gap;
        logic [167:0] word;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        word = '0;
        for (int i = 0; i < 9; i++) word[16*i +: 16] = px[i];
        word[144 +: 20] = idx;
        s_tvalid <= 1'b1;
        s_tdata <= word;
        s_tuser <= fresh;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(predict_ridge(px, idx, fresh));
        sent_count++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(logic [1:0] index, logic [31:0] value);
        apb_active = 1'b1;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (index)
            REG_SIGMA_SQUARED:  sigma_sq_q = value[15:0];
            REG_RATIO_LIMIT:    ratio_q = value[8:0];
            REG_STRENGTH_LIMIT: strength_q = value[15:0];
            default: ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        apb_active = 1'b0;
    endtask

    task automatic configure(logic [15:0] sg, logic [8:0] rl, logic [15:0] sl);
        wait_idle();
        write_register(REG_SIGMA_SQUARED, 32'(sg));
        write_register(REG_RATIO_LIMIT, 32'(rl));
        write_register(REG_STRENGTH_LIMIT, 32'(sl));
    endtask

    task automatic send_flat(logic [15:0] lvl, logic [15:0] ctr, logic [19:0] idx, bit fresh);
        logic [15:0] px[9];
        foreach (px[i]) px[i] = lvl;
        px[4] = ctr;
        send_pixel(px, idx, fresh);
    endtask

    task automatic send_random_pixel();
        logic [15:0] px[9];
        logic [15:0] base;
        logic [19:0] idx;
        int spread;
        base = 16'($urandom_range(0, 65535));
        spread = $urandom_range(0, 3) == 0 ? 65535 : (1 << $urandom_range(2, 12));
        foreach (px[i]) begin
            if (spread == 65535) px[i] = 16'($urandom_range(0, 65535));
            else px[i] = 16'(base + $urandom_range(0, spread));
        end
        idx = $urandom_range(0, 9) == 0 ? 20'($urandom) : 20'($urandom_range(0, 63));
        send_pixel(px, idx, $urandom_range(0, 9) == 0);
    endtask

    task automatic test_reset_values();
        send_flat(16'd1000, 16'd0, 20'd10, 1'b0);
        send_flat(16'd0, 16'd5000, 20'd11, 1'b0);
        send_flat(16'd300, 16'd300, 20'd12, 1'b0);
    endtask

    task automatic test_directed();
        logic [15:0] px[9];
        configure(16'd16, 9'd256, 16'd0);
        send_flat(16'd0, 16'd0, 20'd0, 1'b0);
        send_flat(16'hFFFF, 16'hFFFF, 20'hFFFFF, 1'b0);
        send_flat(16'hFFFF, 16'd0, 20'd1, 1'b0);
        send_flat(16'd0, 16'hFFFF, 20'd2, 1'b0);
        // dark first, then light on same pixel stays dark only; after a new image the reverse holds
        send_flat(16'd0, 16'hFFFF, 20'd3, 1'b0);
        send_flat(16'hFFFF, 16'd0, 20'd3, 1'b0);
        send_flat(16'hFFFF, 16'd0, 20'd3, 1'b1);
        send_flat(16'd0, 16'hFFFF, 20'd3, 1'b0);
        px = '{16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF};
        send_pixel(px, 20'd4, 1'b0);
        px = '{16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0};
        send_pixel(px, 20'd5, 1'b0);
        px = '{16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0};
        send_pixel(px, 20'd6, 1'b0);
        configure(16'hFFFF, 9'd0, 16'hFFFF);
        send_flat(16'hFFFF, 16'd0, 20'd7, 1'b0);
        send_flat(16'd0, 16'hFFFF, 20'd8, 1'b0);
        configure(16'hFFFF, 9'd511, 16'd0);
        send_flat(16'hFFFF, 16'd0, 20'd20, 1'b0);
        px = '{16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF};
        send_pixel(px, 20'd21, 1'b0);
        configure(16'd0, 9'd256, 16'd0);
        send_flat(16'hFFFF, 16'd0, 20'd22, 1'b0);
        // write to an unused register address is dropped
        wait_idle();
        write_register(REG_UNMAPPED, 32'hFFFF_FFFF);
        send_flat(16'd0, 16'd0, 20'hFFFFF, 1'b1);
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        configure(16'($urandom_range(1, 64)), 9'($urandom_range(0, 511)),
                  16'($urandom_range(0, 40)));
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            if (i % 200 == 199)
                configure(16'($urandom_range(0, 65535) >> $urandom_range(0, 12)),
                          9'($urandom_range(0, 511)), 16'($urandom_range(0, 60)));
            send_random_pixel();
        end
    endtask

    task automatic test_output_hold_off();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 400;
        for (int i = 0; i < 80; i++) send_random_pixel();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            m_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            m_tready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[62:0];
            checked_count++;
            if (got.resp != 0) nonzero_count++;
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) $error("unexpected transaction %h", m_tdata);
            end else begin
                want = expected_results.pop_front();
                if (got.idx != want.idx || got.resp != want.resp || got.dark != want.dark
                        || got.light != want.light || m_tdata[63] != 1'b0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        if (got.idx != want.idx)
                            $error("out_index expected %0d actual %0d", want.idx, got.idx);
                        if (got.resp != want.resp)
                            $error("response expected %0d actual %0d",
                                   $signed(want.resp), $signed(got.resp));
                        if (got.dark != want.dark)
                            $error("dark_on_light expected %0d actual %0d", want.dark, got.dark);
                        if (got.light != want.light)
                            $error("light_on_dark expected %0d actual %0d",
                                   want.light, got.light);
                        if (m_tdata[63] != 1'b0)
                            $error("fill bit expected 0 actual 1");
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || apb_active) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        sigma_sq_q = 16'd12;
        ratio_q = 9'd230;
        strength_q = 16'd23;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_values();
        test_directed();
        test_random(650, 26, 79);
        test_random(650, 79, 26);
        test_random(650, 0, 0);
        test_output_hold_off();
        wait_idle();
        $display("sent %0d pixels, checked %0d results, %0d with nonzero response",
                 sent_count, checked_count, nonzero_count);
        $display("covered field extremes, flag exclusivity, new image, register extremes, stalls");
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
